@@ sv/wrrtp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrrtp_pkg
// Shared types and constants of the weighted round-robin task picker.
// ----------------------------------------------------------------------------
package wrrtp_pkg;

    localparam int MAX_TASKS = 16;
    localparam int IDX_W     = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);

    localparam int S_DATA_W  = 120;
    localparam int M_DATA_W  = 48;

    // flag bit positions
    localparam int FLG_ACTIVE = 0;
    localparam int FLG_WAIT   = 1;
    localparam int FLG_MSG    = 2;
    localparam int FLG_YIELD  = 3;
    localparam int FLG_EXIT   = 4;

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_APPEND  = 2'd1,
        CMD_REWRITE = 2'd2,
        CMD_NOP     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_SLOT = 2'd2,
        ST_RSVD = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_TASK = 2'd1,
        KIND_IDLE = 2'd2,
        KIND_RSVD = 2'd3
    } kind_t;

    typedef struct packed {
        logic [31:0] id;
        logic [7:0]  prio;
        logic [7:0]  step;
        logic [4:0]  flags;
        logic [31:0] deadline;
    } entry_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic misc;
        logic exit_chk;
        logic compact;
        logic prio;
        logic hunt;
        logic emit;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic tick_en;
        logic walk_end;
        logic prio_hit;
        logic hunt_done;
        logic out_busy;
    } dp_stat_t;

endpackage

@@ sv/wrrtp_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrrtp_ctrl
// Sequencer: steps an item through decode and, for an enabled tick, exit
// check, compaction, weighted pass, round-robin hunt if no hit, and output.
// ----------------------------------------------------------------------------
module wrrtp_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  wrrtp_pkg::dp_stat_t  stat,
    output wrrtp_pkg::ctrl_cmd_t cmd
);

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_DECODE  = 7'b0000010,
        S_EXIT    = 7'b0000100,
        S_COMPACT = 7'b0001000,
        S_PRIO    = 7'b0010000,
        S_HUNT    = 7'b0100000,
        S_OUT     = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.tick_en)
                begin
                    state_next = S_EXIT;
                end
                else
                begin
                    cmd.misc   = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_EXIT:
            begin
                cmd.exit_chk = 1'b1;
                state_next   = S_COMPACT;
            end
            S_COMPACT:
            begin
                cmd.compact = 1'b1;
                if (stat.walk_end)
                begin
                    state_next = S_PRIO;
                end
            end
            S_PRIO:
            begin
                cmd.prio = 1'b1;
                if (stat.walk_end)
                begin
                    state_next = S_HUNT;
                end
                else if (stat.prio_hit)
                begin
                    state_next = S_OUT;
                end
            end
            S_HUNT:
            begin
                cmd.hunt = 1'b1;
                if (stat.hunt_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ sv/wrrtp_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrrtp_dpath
// Task table, cursor and running-task state, one table read port and one
// write port, result and output registers.
// ----------------------------------------------------------------------------
module wrrtp_dpath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic                                cfg_wdata,
    input  logic [1:0]                          s_tuser,
    input  logic [wrrtp_pkg::S_DATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [wrrtp_pkg::M_DATA_W-1:0]      m_tdata,
    input  wrrtp_pkg::ctrl_cmd_t                cmd,
    output wrrtp_pkg::dp_stat_t                 stat
);

    localparam int IW = wrrtp_pkg::IDX_W;
    localparam int CW = wrrtp_pkg::CNT_W;

    wrrtp_pkg::entry_t tab_reg [wrrtp_pkg::MAX_TASKS];

    // captured item
    wrrtp_pkg::cmd_t   op_reg;
    logic [IW-1:0]     slot_reg;
    wrrtp_pkg::entry_t item_reg;
    logic [31:0]       now_reg;

    logic              enable_reg;
    logic [CW-1:0]     count_reg,   count_next;
    logic [CW-1:0]     cursor_reg,  cursor_next;
    logic [IW-1:0]     rslot_reg,   rslot_next;
    wrrtp_pkg::kind_t  kind_reg,    kind_next;
    logic [CW-1:0]     rd_reg,      rd_next;
    logic [CW-1:0]     wr_reg,      wr_next;
    logic              wrapped_reg, wrapped_next;

    logic [31:0]       res_id_reg,   res_id_next;
    logic              res_idle_reg, res_idle_next;
    logic              res_sw_reg,   res_sw_next;
    wrrtp_pkg::status_t res_st_reg,  res_st_next;

    logic                        out_valid_reg, out_valid_next;
    logic [wrrtp_pkg::M_DATA_W-1:0] out_data_reg;

    logic [IW-1:0]     ridx;
    wrrtp_pkg::entry_t rd_e;
    logic              we;
    logic [IW-1:0]     waddr;
    wrrtp_pkg::entry_t wdata;

    wrrtp_pkg::entry_t e;
    logic              keep;
    logic              elig;
    logic [7:0]        step_inc;
    logic [CW-1:0]     nc;
    logic [CW-1:0]     hc;
    logic              wrap_now;
    logic              prio_hit;
    logic              hunt_done;

    // next round-robin position
    assign nc       = cursor_reg + CW'(1);
    assign wrap_now = (nc >= count_reg);
    assign hc       = wrap_now ? '0 : nc;

    // table read address
    always_comb
    begin
        ridx = rd_reg[IW-1:0];
        if (cmd.misc && op_reg == wrrtp_pkg::CMD_REWRITE)
        begin
            ridx = slot_reg;
        end
        else if (cmd.misc)
        begin
            ridx = rslot_reg;
        end
        else if (cmd.exit_chk)
        begin
            ridx = cursor_reg[IW-1:0];
        end
        else if (cmd.hunt)
        begin
            ridx = hc[IW-1:0];
        end
    end

    assign rd_e = tab_reg[ridx];

    always_comb
    begin
        count_next    = count_reg;
        cursor_next   = cursor_reg;
        rslot_next    = rslot_reg;
        kind_next     = kind_reg;
        rd_next       = rd_reg;
        wr_next       = wr_reg;
        wrapped_next  = wrapped_reg;
        res_id_next   = res_id_reg;
        res_idle_next = res_idle_reg;
        res_sw_next   = res_sw_reg;
        res_st_next   = res_st_reg;
        we            = 1'b0;
        waddr         = wr_reg[IW-1:0];
        wdata         = item_reg;
        e             = rd_e;
        keep          = 1'b1;
        elig          = 1'b0;
        step_inc      = rd_e.step + 8'd1;
        prio_hit      = 1'b0;
        hunt_done     = 1'b0;

        if (cmd.misc)
        begin
            res_id_next   = '0;
            res_idle_next = 1'b0;
            res_sw_next   = 1'b0;
            res_st_next   = wrrtp_pkg::ST_OK;
            case (op_reg)
                wrrtp_pkg::CMD_TICK:
                begin
                    // disabled tick reports the current runner
                    if (kind_reg == wrrtp_pkg::KIND_TASK && {1'b0, rslot_reg} < count_reg)
                    begin
                        res_id_next = rd_e.id;
                    end
                    res_idle_next = (kind_reg == wrrtp_pkg::KIND_IDLE);
                end
                wrrtp_pkg::CMD_APPEND:
                begin
                    if (count_reg >= CW'(wrrtp_pkg::MAX_TASKS))
                    begin
                        res_st_next = wrrtp_pkg::ST_FULL;
                    end
                    else
                    begin
                        we         = 1'b1;
                        waddr      = count_reg[IW-1:0];
                        wdata      = item_reg;
                        wdata.step = '0;
                        count_next = count_reg + CW'(1);
                    end
                end
                wrrtp_pkg::CMD_REWRITE:
                begin
                    if ({1'b0, slot_reg} >= count_reg)
                    begin
                        res_st_next = wrrtp_pkg::ST_SLOT;
                    end
                    else
                    begin
                        we         = 1'b1;
                        waddr      = slot_reg;
                        wdata      = item_reg;
                        wdata.step = rd_e.step;
                    end
                end
                default:
                begin
                    res_st_next = wrrtp_pkg::ST_OK;
                end
            endcase
        end

        if (cmd.exit_chk)
        begin
            if (kind_reg != wrrtp_pkg::KIND_NONE && count_reg != '0 &&
                cursor_reg < count_reg && rd_e.flags[wrrtp_pkg::FLG_EXIT])
            begin
                kind_next = wrrtp_pkg::KIND_NONE;
            end
            rd_next      = '0;
            wr_next      = '0;
            wrapped_next = 1'b0;
        end

        if (cmd.compact)
        begin
            if (rd_reg >= count_reg)
            begin
                count_next = wr_reg;
                rd_next    = '0;
            end
            else
            begin
                // end of wait, then drop exiting tasks other than the runner
                if (e.flags[wrrtp_pkg::FLG_WAIT] &&
                    (e.flags[wrrtp_pkg::FLG_MSG] || rd_e.deadline < now_reg))
                begin
                    e.flags[wrrtp_pkg::FLG_WAIT] = 1'b0;
                    e.deadline                   = '0;
                end
                keep = !(e.flags[wrrtp_pkg::FLG_EXIT] &&
                         !(kind_reg == wrrtp_pkg::KIND_TASK && rslot_reg == rd_reg[IW-1:0]));
                if (keep)
                begin
                    we    = 1'b1;
                    waddr = wr_reg[IW-1:0];
                    wdata = e;
                    if (kind_reg == wrrtp_pkg::KIND_TASK && rslot_reg == rd_reg[IW-1:0])
                    begin
                        rslot_next = wr_reg[IW-1:0];
                    end
                    wr_next = wr_reg + CW'(1);
                end
                rd_next = rd_reg + CW'(1);
            end
        end

        if (cmd.prio && rd_reg < count_reg)
        begin
            elig = (rd_e.prio != '0) && !rd_e.flags[wrrtp_pkg::FLG_EXIT] &&
                   (rd_e.deadline == '0) && rd_e.flags[wrrtp_pkg::FLG_ACTIVE] &&
                   !rd_e.flags[wrrtp_pkg::FLG_WAIT] && !rd_e.flags[wrrtp_pkg::FLG_YIELD];
            if (elig)
            begin
                we    = 1'b1;
                waddr = rd_reg[IW-1:0];
                wdata = rd_e;
                if (step_inc >= rd_e.prio)
                begin
                    wdata.step    = '0;
                    prio_hit      = 1'b1;
                    cursor_next   = rd_reg;
                    res_sw_next   = !(kind_reg == wrrtp_pkg::KIND_TASK &&
                                      rslot_reg == rd_reg[IW-1:0]);
                    kind_next     = wrrtp_pkg::KIND_TASK;
                    rslot_next    = rd_reg[IW-1:0];
                    res_id_next   = rd_e.id;
                    res_idle_next = 1'b0;
                    res_st_next   = wrrtp_pkg::ST_OK;
                end
                else
                begin
                    wdata.step = step_inc;
                end
            end
            rd_next = rd_reg + CW'(1);
        end

        if (cmd.hunt)
        begin
            if (wrap_now && wrapped_reg)
            begin
                // second wrap without a candidate
                hunt_done   = 1'b1;
                cursor_next = nc;
                wrapped_next = 1'b1;
            end
            else
            begin
                cursor_next  = hc;
                wrapped_next = wrapped_reg | wrap_now;
                if (count_reg == '0)
                begin
                    hunt_done = 1'b1;
                end
                else
                begin
                    if (e.deadline != '0 && e.deadline < now_reg)
                    begin
                        e.deadline = '0;
                    end
                    if (e.deadline == '0 && e.flags[wrrtp_pkg::FLG_ACTIVE] &&
                        !e.flags[wrrtp_pkg::FLG_WAIT] && !e.flags[wrrtp_pkg::FLG_EXIT])
                    begin
                        if (e.flags[wrrtp_pkg::FLG_YIELD])
                        begin
                            e.flags[wrrtp_pkg::FLG_YIELD] = 1'b0;
                            wrapped_next                  = 1'b0;
                        end
                        else if (e.prio == '0)
                        begin
                            wrapped_next = 1'b0;
                            hunt_done    = 1'b1;
                        end
                    end
                    we    = 1'b1;
                    waddr = hc[IW-1:0];
                    wdata = e;
                end
            end
            if (hunt_done)
            begin
                res_st_next = wrrtp_pkg::ST_OK;
                if (wrapped_next)
                begin
                    res_sw_next   = (kind_reg != wrrtp_pkg::KIND_IDLE);
                    kind_next     = wrrtp_pkg::KIND_IDLE;
                    res_id_next   = '0;
                    res_idle_next = 1'b1;
                end
                else
                begin
                    res_sw_next   = !(kind_reg == wrrtp_pkg::KIND_TASK &&
                                      rslot_reg == hc[IW-1:0]);
                    kind_next     = wrrtp_pkg::KIND_TASK;
                    rslot_next    = hc[IW-1:0];
                    res_id_next   = rd_e.id;
                    res_idle_next = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    assign stat.tick_en   = (op_reg == wrrtp_pkg::CMD_TICK) && enable_reg;
    assign stat.walk_end  = (rd_reg >= count_reg);
    assign stat.prio_hit  = prio_hit;
    assign stat.hunt_done = hunt_done;
    assign stat.out_busy  = out_valid_reg && !m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // table storage, no reset
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            tab_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg         <= wrrtp_pkg::cmd_t'(s_tuser);
            slot_reg       <= s_tdata[3:0];
            item_reg.id    <= s_tdata[35:4];
            item_reg.prio  <= s_tdata[43:36];
            item_reg.step  <= '0;
            item_reg.flags <= s_tdata[48:44];
            item_reg.deadline <= s_tdata[80:49];
            now_reg        <= s_tdata[112:81];
        end
        res_id_reg   <= res_id_next;
        res_idle_reg <= res_idle_next;
        res_sw_reg   <= res_sw_next;
        res_st_reg   <= res_st_next;
        if (cmd.emit)
        begin
            out_data_reg <= {7'd0, count_reg, res_st_reg, res_sw_reg, res_idle_reg, res_id_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b0;
            count_reg     <= '0;
            cursor_reg    <= '0;
            rslot_reg     <= '0;
            kind_reg      <= wrrtp_pkg::KIND_NONE;
            rd_reg        <= '0;
            wr_reg        <= '0;
            wrapped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                enable_reg <= cfg_wdata;
            end
            count_reg     <= count_next;
            cursor_reg    <= cursor_next;
            rslot_reg     <= rslot_next;
            kind_reg      <= kind_next;
            rd_reg        <= rd_next;
            wr_reg        <= wr_next;
            wrapped_reg   <= wrapped_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(wrrtp_pkg::MAX_TASKS))
        else $error("task count beyond table size");

    a_runner_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (kind_reg == wrrtp_pkg::KIND_TASK) |-> ({1'b0, rslot_reg} < count_reg))
        else $error("running slot outside table");

    a_compact_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.compact |-> (wr_reg <= rd_reg))
        else $error("compaction write pointer passed read pointer");

    a_hit_sets_runner: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.prio && prio_hit) |=> (kind_reg == wrrtp_pkg::KIND_TASK &&
                                    {1'b0, rslot_reg} == cursor_reg))
        else $error("weighted pick did not update runner");

endmodule

@@ sv/weighted_round_robin_task_picker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_round_robin_task_picker
// Task table with append/rewrite commands and a weighted round-robin pick.
// ----------------------------------------------------------------------------
// One item at a time. Append, rewrite, unused command and a disabled tick
// go through decode and output before m_tvalid rises. An enabled tick walks
// the table through its single read port: decode, exit check, wait release
// and compaction, the weighted pass, then, if that pass picks no task, one
// round-robin hunt step per entry (the hunt ends at a second wrap with no
// candidate, and a cleared yield restarts that limit) and the output step.
// A new item is taken while a finished result still waits in the output
// register; the next result then waits in the output step until it drains.
module weighted_round_robin_task_picker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic                           cfg_wdata,   // enable
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [1:0]                     s_tuser,     // command
    // slot[3:0], task_id[35:4], priority_req[43:36], active[44], waiting[45],
    // message_pending[46], yielded[47], exit_request[48], deadline[80:49],
    // now[112:81], zero fill
    input  logic [wrrtp_pkg::S_DATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // chosen_id[31:0], idle[32], switched[33], status[35:34],
    // task_count[40:36], zero fill
    output logic [wrrtp_pkg::M_DATA_W-1:0] m_tdata
);

    wrrtp_pkg::ctrl_cmd_t cmd;
    wrrtp_pkg::dp_stat_t  stat;

    wrrtp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    wrrtp_dpath u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
